// File: design/tpit_pkg.sv
// ----------------------------------------------------------------------------
// Touch point ID tracker package
// Shared widths, register map, item codes, state encoding and the structs
// that travel between the tracker's modules.
// ----------------------------------------------------------------------------
package tpit_pkg;

  localparam int COORD_W  = 16;
  localparam int ID_W     = 16;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int SUM_W    = SQ_W + 1;
  localparam int CUTOFF_W = 34;

  // Configuration port: one 34-bit register at an 8-byte stride.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;
  localparam logic REG_CUTOFF = 1'b0;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 34'd2048000;

  // Item codes on the input channel.
  localparam logic FUNC_POINT = 1'b0;
  localparam logic FUNC_EOF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // One stored point of the previous frame.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ID_W-1:0]    ident;
    logic               taken;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic handoff;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic feed;
  } dist_ctrl_t;

endpackage

// File: design/tpit_if.sv
// ----------------------------------------------------------------------------
// Touch point ID tracker channels
// Valid/ready channels for touch point items and for tracking results.
// ----------------------------------------------------------------------------
interface tpit_in_if;
  import tpit_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;

  modport source (output valid, func, pos_x, pos_y, input ready);
  modport sink   (input valid, func, pos_x, pos_y, output ready);
endinterface

interface tpit_out_if;
  import tpit_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] touch_id;
  logic            is_new;
  logic            dropped;

  modport source (output valid, touch_id, is_new, dropped, input ready);
  modport sink   (input valid, touch_id, is_new, dropped, output ready);
endinterface

// File: design/tpit_cell.sv
// ----------------------------------------------------------------------------
// Touch point ID tracker cell
// Holds one previous-frame entry, which rotates through the ring, and one
// current-frame entry, which is copied into the previous slot at end of frame.
// ----------------------------------------------------------------------------
module tpit_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  tpit_pkg::cell_ctrl_t         ctrl,
  input  logic                         cur_we,
  input  logic                         take,
  input  logic [tpit_pkg::COORD_W-1:0] wr_x,
  input  logic [tpit_pkg::COORD_W-1:0] wr_y,
  input  logic [tpit_pkg::ID_W-1:0]    wr_ident,
  input  tpit_pkg::entry_t             nbr,
  output tpit_pkg::entry_t             prev
);
  import tpit_pkg::*;

  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [ID_W-1:0]    cur_ident;
  logic [COORD_W-1:0] prev_x;
  logic [COORD_W-1:0] prev_y;
  logic [ID_W-1:0]    prev_ident;
  logic               prev_taken;

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_x     <= wr_x;
      cur_y     <= wr_y;
      cur_ident <= wr_ident;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.handoff) begin
      prev_x     <= cur_x;
      prev_y     <= cur_y;
      prev_ident <= cur_ident;
    end else if (ctrl.shift) begin
      prev_x     <= nbr.x;
      prev_y     <= nbr.y;
      prev_ident <= nbr.ident;
    end
  end

  // The taken mark travels with its entry and is cleared on every new frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_taken <= 1'b0;
    end else if (ctrl.handoff) begin
      prev_taken <= 1'b0;
    end else if (ctrl.shift) begin
      prev_taken <= nbr.taken;
    end else if (take) begin
      prev_taken <= 1'b1;
    end
  end

  assign prev = '{x: prev_x, y: prev_y, ident: prev_ident, taken: prev_taken};

endmodule

// File: design/tpit_dist.sv
// ----------------------------------------------------------------------------
// Touch point ID tracker distance unit
// Pipelined squared distance of the ring head to the probe point, followed by
// a running minimum that keeps the earliest of equal distances.
// ----------------------------------------------------------------------------
module tpit_dist #(
  parameter int IDX_W = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tpit_pkg::dist_ctrl_t          ctrl,
  input  logic [IDX_W-1:0]              idx,
  input  tpit_pkg::entry_t              head,
  input  logic [tpit_pkg::COORD_W-1:0]  probe_x,
  input  logic [tpit_pkg::COORD_W-1:0]  probe_y,
  input  logic [tpit_pkg::CUTOFF_W-1:0] cutoff,
  output logic                          found,
  output logic [IDX_W-1:0]              best_idx,
  output logic [tpit_pkg::ID_W-1:0]     best_ident
);
  import tpit_pkg::*;

  logic               a_vld;
  logic [COORD_W-1:0] a_dx;
  logic [COORD_W-1:0] a_dy;
  logic [IDX_W-1:0]   a_idx;
  logic [ID_W-1:0]    a_ident;
  logic               b_vld;
  logic [SQ_W-1:0]    b_sqx;
  logic [SQ_W-1:0]    b_sqy;
  logic [IDX_W-1:0]   b_idx;
  logic [ID_W-1:0]    b_ident;
  logic               c_vld;
  logic [SUM_W-1:0]   c_sum;
  logic [IDX_W-1:0]   c_idx;
  logic [ID_W-1:0]    c_ident;
  logic [SUM_W-1:0]   best_d;
  logic               hit;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      a_vld <= ctrl.feed;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_dx    <= (probe_x >= head.x) ? probe_x - head.x : head.x - probe_x;
    a_dy    <= (probe_y >= head.y) ? probe_y - head.y : head.y - probe_y;
    a_idx   <= idx;
    a_ident <= head.ident;
    b_sqx   <= a_dx * a_dx;
    b_sqy   <= a_dy * a_dy;
    b_idx   <= a_idx;
    b_ident <= a_ident;
    c_sum   <= SUM_W'(b_sqx) + SUM_W'(b_sqy);
    c_idx   <= b_idx;
    c_ident <= b_ident;
  end

  // Strict compares keep the first entry among equal distances.
  assign hit = c_vld && (CUTOFF_W'(c_sum) < cutoff) && (!found || c_sum < best_d);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      found <= 1'b0;
    end else if (hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      best_d     <= c_sum;
      best_idx   <= c_idx;
      best_ident <= c_ident;
    end
  end

`ifndef SYNTH
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    c_vld |-> $past(b_vld))
    else $error("distance stage C valid without stage B the cycle before");
  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    hit |=> found && best_d == $past(c_sum))
    else $error("running minimum not updated on a hit");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> !found && !a_vld && !b_vld && !c_vld)
    else $error("distance unit not cleared at start of a point");
`endif

endmodule

// File: design/touch_point_id_tracker.sv
// ----------------------------------------------------------------------------
// Touch point ID tracker
// Greedy nearest-neighbor ID assignment of touch points across frames.
// ----------------------------------------------------------------------------
// Touch points of a frame arrive one per transfer on in_ch, and each yields
// one result transfer on out_ch with its ID: either the ID of the closest
// previous-frame point not yet taken this frame whose squared distance (in
// 1/256 pixel squared) is strictly below cutoff_sq, the earliest one on a tie,
// or a fresh ID from a 16-bit wrapping counter (the first fresh ID after reset
// is 1). An end-of-frame transfer (func = 1) makes the current list the
// previous list in the cycle it is taken and gives no result. Points beyond
// MAX_POINTS in a frame still get IDs but are flagged dropped and not kept.
// A touch point occupies the block from its transfer until its result is
// committed, and no new item is taken in that time; an end-of-frame item
// is taken in the idle state and does not leave it. While a point is
// processed, the previous-frame entries rotate one position per cycle
// through a ring of cells past a single distance unit with three pipeline
// stages A, B and C, and the result is then committed. A finished result
// sits in an output register, so the next item is taken while it waits.
// cutoff_sq is at byte addresses 0-7 of the APB port (64-bit data); writes to
// other addresses are ignored, and it should be written only while idle.
// ----------------------------------------------------------------------------
module touch_point_id_tracker #(
  parameter int MAX_POINTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  tpit_in_if.sink                     in_ch,
  tpit_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpit_pkg::ADDR_W-1:0] paddr,
  input  logic [tpit_pkg::DATA_W-1:0] pwdata,
  output logic [tpit_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tpit_pkg::*;

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int STEP_W = $clog2(MAX_POINTS + 3);
  // The last entry leaves the ring at step MAX_POINTS - 1 and reaches the
  // running minimum through the distance registers A, B and C.
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(MAX_POINTS + 2);
  localparam logic [STEP_W-1:0] SCAN_STEPS = STEP_W'(MAX_POINTS);

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  logic [COORD_W-1:0]  probe_x;
  logic [COORD_W-1:0]  probe_y;
  logic [CNT_W-1:0]    cur_count;
  logic [CNT_W-1:0]    prev_count;
  logic [ID_W-1:0]     id_counter;
  logic [CUTOFF_W-1:0] cutoff_sq;

  logic                out_valid;
  logic [ID_W-1:0]     out_touch_id;
  logic                out_is_new;
  logic                out_dropped;

  logic                in_fire;
  logic                eof;
  logic                shift;
  logic                commit;
  logic                keep;
  logic                cfg_write;
  logic [ID_W-1:0]     fresh_id;
  logic [ID_W-1:0]     commit_ident;

  logic                found;
  logic [IDX_W-1:0]    best_idx;
  logic [ID_W-1:0]     best_ident;

  cell_ctrl_t          cell_ctrl;
  dist_ctrl_t          dist_ctrl;
  entry_t              ring [MAX_POINTS];
  logic [MAX_POINTS-1:0] cur_we;
  logic [MAX_POINTS-1:0] take;

  // Handshake and end-of-frame handoff.
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign eof         = in_fire && (in_ch.func == FUNC_EOF);

  // Sequencer: accept, rotate the ring through the distance unit, commit.
  always_comb begin
    state_next = state;
    step_next  = step;
    shift      = 1'b0;
    commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_fire && in_ch.func == FUNC_POINT) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift     = (step < SCAN_STEPS);
        step_next = step + 1'b1;
        if (step == LAST_STEP) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // Wait here only while an older result has not been transferred.
        if (!out_valid || out_ch.ready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      probe_x <= in_ch.pos_x;
      probe_y <= in_ch.pos_y;
    end
  end

  // The ring head is entry number step while the ring rotates; entries past
  // the previous count or already taken are not offered to the distance unit.
  assign cell_ctrl.shift   = shift;
  assign cell_ctrl.handoff = eof;
  assign dist_ctrl.clear   = in_fire && (in_ch.func == FUNC_POINT);
  assign dist_ctrl.feed    = shift && (step < STEP_W'(prev_count)) && !ring[0].taken;

  assign keep         = (cur_count < CNT_W'(MAX_POINTS));
  assign fresh_id     = id_counter + 1'b1;
  assign commit_ident = found ? best_ident : fresh_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count  <= '0;
      prev_count <= '0;
      id_counter <= '0;
    end else if (eof) begin
      prev_count <= cur_count;
      cur_count  <= '0;
    end else if (commit) begin
      if (!found) begin
        id_counter <= fresh_id;
      end
      if (keep) begin
        cur_count <= cur_count + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_touch_id <= commit_ident;
      out_is_new   <= !found;
      out_dropped  <= !keep;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.touch_id = out_touch_id;
  assign out_ch.is_new   = out_is_new;
  assign out_ch.dropped  = out_dropped;

  // Ring of cells: each takes its upper neighbor's entry, the last wraps to
  // the head, so after MAX_POINTS shifts every entry is home again.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign cur_we[i] = commit && keep && (cur_count == CNT_W'(i));
    assign take[i]   = commit && found && (best_idx == IDX_W'(i));

    tpit_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .cur_we   (cur_we[i]),
      .take     (take[i]),
      .wr_x     (probe_x),
      .wr_y     (probe_y),
      .wr_ident (commit_ident),
      .nbr      (ring[(i + 1) % MAX_POINTS]),
      .prev     (ring[i])
    );
  end

  tpit_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (dist_ctrl),
    .idx        (step[IDX_W-1:0]),
    .head       (ring[0]),
    .probe_x    (probe_x),
    .probe_y    (probe_y),
    .cutoff     (cutoff_sq),
    .found      (found),
    .best_idx   (best_idx),
    .best_ident (best_ident)
  );

  // Configuration register; the register index is the address bit above the
  // 8-byte register slot.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_sq <= CUTOFF_RESET;
    end else if (cfg_write) begin
      case (paddr[ADDR_W-1])
        REG_CUTOFF: cutoff_sq <= pwdata[CUTOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1])
      REG_CUTOFF: prdata = DATA_W'(cutoff_sq);
      default:    prdata = '0;
    endcase
  end

`ifndef SYNTH
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> step <= LAST_STEP)
    else $error("scan step counter ran past the last step");
  a_cur_bound: assert property (@(posedge clk) disable iff (rst)
    cur_count <= CNT_W'(MAX_POINTS) && prev_count <= CNT_W'(MAX_POINTS))
    else $error("point count exceeds the list capacity");
  a_fresh_id: assert property (@(posedge clk) disable iff (rst)
    commit && !found |=> id_counter == $past(id_counter) + 16'd1)
    else $error("fresh ID not taken from the advanced counter");
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    eof |=> cur_count == '0 && prev_count == $past(cur_count))
    else $error("end of frame did not hand the current list over");
`endif

endmodule
